// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the handle allocator RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted
`define GHA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("handle allocator assertion failed");

// Clocked check that also holds during reset
`define GHA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("handle allocator assertion failed");

`else

`define GHA_ASSERT(lbl, prop)
`define GHA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: sv/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Types, widths and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gha_pkg;

    // Pool geometry
    localparam int DEPTH            = 1024;
    localparam int IDX_W            = $clog2(DEPTH);
    localparam int INDEX_FIELD_BITS = 11;
    localparam int GEN_W            = 8;
    localparam int HANDLE_W         = 19;
    localparam int CNT_W            = 11;
    // Slot word: {generation, busy}
    localparam int SLOT_W           = GEN_W + 1;

    // Opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [1:0] STAT_BAD       = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] handle_in;
    } gha_in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          status;
        logic                is_valid;
    } gha_out_t;

    // Result handed from the controller to the output register
    typedef struct packed {
        logic     valid;
        gha_out_t item;
    } gha_res_t;

    // Controller status
    typedef struct packed {
        logic             clearing;
        logic [CNT_W-1:0] free_count;
    } gha_stat_t;

endpackage

// File: sv/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer of the handle allocator. Owns the free-stack RAM and the slot
// RAM ({generation, busy}), runs the clearing pass and the per-item
// read-modify-write of the two memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gha_ctrl
    import gha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_load,
    input  logic [CNT_W-1:0] pool_size,
    input  logic             in_valid,
    output logic             in_stall,
    input  gha_in_t          in_item,
    input  logic             out_free,
    output gha_res_t         res,
    output gha_stat_t        stat
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STACK,
        S_ALLOC,
        S_SLOT,
        S_HOLD
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]     free_count_reg, free_count_next;
    logic [1:0]           op_reg, op_next;
    logic [GEN_W-1:0]     hgen_reg, hgen_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    gha_out_t             hold_reg, hold_next;

    // Memory ports
    logic                 stk_we, stk_re;
    logic [IDX_W-1:0]     stk_waddr, stk_raddr;
    logic [IDX_W-1:0]     stk_wdata, stk_rdata;
    logic                 slt_we, slt_re;
    logic [IDX_W-1:0]     slt_waddr, slt_raddr;
    logic [SLOT_W-1:0]    slt_wdata, slt_rdata;

    // Decode helpers
    logic [INDEX_FIELD_BITS-1:0] field, field_m1, idx_p1;
    logic                        field_bad;
    logic [CNT_W-1:0]            clr_ext, clr_val, fc_m1;
    logic [GEN_W-1:0]            slot_gen;
    logic                        slot_busy, slot_ok;
    logic                        accept;
    gha_out_t                    imm;

    gha_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    gha_ram #(.DATA_W(SLOT_W), .ADDR_W(IDX_W)) u_slot_ram (
        .clk   (clk),
        .we    (slt_we),
        .waddr (slt_waddr),
        .wdata (slt_wdata),
        .re    (slt_re),
        .raddr (slt_raddr),
        .rdata (slt_rdata)
    );

    // Handle decode and slot compare
    assign field     = in_item.handle_in[INDEX_FIELD_BITS-1:0];
    assign field_m1  = field - INDEX_FIELD_BITS'(1);
    assign field_bad = (field == '0) || (CNT_W'(field) > pool_size);
    assign idx_p1    = INDEX_FIELD_BITS'(idx_reg) + INDEX_FIELD_BITS'(1);
    assign slot_gen  = slt_rdata[SLOT_W-1:1];
    assign slot_busy = slt_rdata[0];
    assign slot_ok   = slot_busy && (slot_gen == hgen_reg);

    // Clearing pass: stack entry i holds pool_size-1-i
    assign clr_ext = CNT_W'(clr_cnt_reg);
    assign clr_val = pool_size - CNT_W'(1) - clr_ext;
    assign fc_m1   = free_count_reg - CNT_W'(1);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    assign stat.clearing   = (state_reg == S_CLEAR);
    assign stat.free_count = free_count_reg;

    // Next-state and memory control
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        free_count_next = free_count_reg;
        op_next         = op_reg;
        hgen_next       = hgen_reg;
        idx_next        = idx_reg;
        hold_next       = hold_reg;
        stk_we          = 1'b0;
        stk_waddr       = '0;
        stk_wdata       = '0;
        stk_re          = 1'b0;
        stk_raddr       = '0;
        slt_we          = 1'b0;
        slt_waddr       = '0;
        slt_wdata       = '0;
        slt_re          = 1'b0;
        slt_raddr       = '0;
        res             = '0;
        imm             = '0;

        case (state_reg)
            S_CLEAR:
            begin
                stk_we    = 1'b1;
                stk_waddr = clr_cnt_reg;
                stk_wdata = (clr_ext < pool_size) ? clr_val[IDX_W-1:0] : '0;
                slt_we    = 1'b1;
                slt_waddr = clr_cnt_reg;
                slt_wdata = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(DEPTH - 1))
                begin
                    free_count_next = pool_size;
                    state_next      = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = in_item.opcode;
                    hgen_next = in_item.handle_in[HANDLE_W-1:INDEX_FIELD_BITS];
                    idx_next  = field_m1[IDX_W-1:0];
                    imm       = '0;
                    case (in_item.opcode)
                        OP_ALLOC:
                        begin
                            if (free_count_reg == '0)
                            begin
                                imm.status = STAT_EXHAUSTED;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                stk_raddr  = fc_m1[IDX_W-1:0];
                                state_next = S_STACK;
                            end
                        end
                        OP_FREE, OP_CHECK:
                        begin
                            if (field_bad)
                            begin
                                imm.status = (in_item.opcode == OP_FREE) ? STAT_BAD : STAT_OK;
                            end
                            else
                            begin
                                slt_re     = 1'b1;
                                slt_raddr  = field_m1[IDX_W-1:0];
                                state_next = S_SLOT;
                            end
                        end
                        default:
                        begin
                            imm = '0;
                        end
                    endcase
                    // Answers that need no memory access
                    if (state_next == S_IDLE)
                    begin
                        if (out_free)
                        begin
                            res.valid = 1'b1;
                            res.item  = imm;
                        end
                        else
                        begin
                            hold_next  = imm;
                            state_next = S_HOLD;
                        end
                    end
                end
            end

            // Stack top is out: fetch that slot
            S_STACK:
            begin
                slt_re     = 1'b1;
                slt_raddr  = stk_rdata;
                idx_next   = stk_rdata;
                state_next = S_ALLOC;
            end

            // Mark slot busy, hand out its handle
            S_ALLOC:
            begin
                if (out_free)
                begin
                    slt_we                = 1'b1;
                    slt_waddr             = idx_reg;
                    slt_wdata             = {slot_gen, 1'b1};
                    free_count_next       = fc_m1;
                    res.valid             = 1'b1;
                    res.item.handle_out   = {slot_gen, idx_p1};
                    res.item.status       = STAT_OK;
                    state_next            = S_IDLE;
                end
            end

            // Free or check against the slot word
            S_SLOT:
            begin
                if (out_free)
                begin
                    res.valid = 1'b1;
                    if (op_reg == OP_FREE)
                    begin
                        if (slot_ok && (free_count_reg < pool_size))
                        begin
                            stk_we          = 1'b1;
                            stk_waddr       = free_count_reg[IDX_W-1:0];
                            stk_wdata       = idx_reg;
                            slt_we          = 1'b1;
                            slt_waddr       = idx_reg;
                            slt_wdata       = {slot_gen + GEN_W'(1), 1'b0};
                            free_count_next = free_count_reg + CNT_W'(1);
                            res.item.status = STAT_OK;
                        end
                        else
                        begin
                            res.item.status = STAT_BAD;
                        end
                    end
                    else
                    begin
                        res.item.is_valid = slot_ok;
                    end
                    state_next = S_IDLE;
                end
            end

            S_HOLD:
            begin
                if (out_free)
                begin
                    res.valid  = 1'b1;
                    res.item   = hold_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // New pool size restarts the clearing pass
        if (cfg_load)
        begin
            state_next   = S_CLEAR;
            clr_cnt_next = '0;
        end
    end

    // State and registered control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            free_count_reg <= CNT_W'(DEPTH);
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            free_count_reg <= free_count_next;
        end
    end

    // Item context (payload, no reset)
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        hgen_reg <= hgen_next;
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
    end

endmodule

// File: sv/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Handle allocator with per-slot generations, free stack and slot RAMs.
//
// Input channel (in_valid/in_stall/in_item): opcode 0 allocates, 1 frees,
// 2 checks a handle. Output channel (out_valid/out_stall/out_item) returns
// one result per item. A transfer happens when valid is high and stall low.
// From input transfer to out_valid, allocate reads the stack, then the
// slot; free and check read the slot; items answered without a memory
// access (empty pool, malformed handle, unused opcode) go straight to the
// output register. The next item is taken in the cycle after a result is
// issued, so the unit takes no new item while one is still in flight; the
// dependent RAM reads keep it busy.
// Reset and every cfg_we write run a clearing pass over all 1024 entries of
// both RAMs; in_stall stays high until it ends. A pool_size of 0 is taken
// as 1, above 1024 as 1024.
// If out_stall holds a result, the unit keeps the next result inside
// until the output register empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module generational_handle_allocator_unit
    import gha_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  gha_in_t          in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output gha_out_t         out_item
);

    logic [CNT_W-1:0] pool_size_reg, pool_size_next;
    logic             out_valid_reg, out_valid_next;
    gha_out_t         out_item_reg, out_item_next;
    logic             out_free;
    gha_res_t         ctrl_res;
    gha_stat_t        ctrl_stat;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_load  (cfg_we),
        .pool_size (pool_size_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_free  (out_free),
        .res       (ctrl_res),
        .stat      (ctrl_stat)
    );

    // Pool size write, clamped to 1..DEPTH
    always_comb
    begin
        pool_size_next = pool_size_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                pool_size_next = CNT_W'(1);
            end
            else if (cfg_wdata > CNT_W'(DEPTH))
            begin
                pool_size_next = CNT_W'(DEPTH);
            end
            else
            begin
                pool_size_next = cfg_wdata;
            end
        end
    end

    // Output register
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (ctrl_res.valid)
        begin
            out_valid_next = 1'b1;
            out_item_next  = ctrl_res.item;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= CNT_W'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pool_size_reg <= pool_size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks
    `GHA_ASSERT(a_res_into_free_slot, ctrl_res.valid |-> out_free)
    `GHA_ASSERT(a_count_in_pool, !ctrl_stat.clearing |-> (ctrl_stat.free_count <= pool_size_reg))
    `GHA_ASSERT_ALWAYS(a_cfg_starts_clear, cfg_we |=> (in_stall && ctrl_stat.clearing))

endmodule

// File: bench/tb_generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator_unit
// Sends allocate, free and check traffic into the handle allocator and
// predicts every answer from a software copy of the slot pool (free stack,
// generations, busy flags). Answers are compared field by field, in order.
// Pool sizes change between phases, and both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_generational_handle_allocator_unit;
    import gha_pkg::*;

    localparam int         CLK_PERIOD    = 10;
    localparam int         RESET_CYCLES  = 9;
    localparam int         QUIET_LIMIT   = 5000;  // covers the clearing pass and the hold-off
    localparam int         MAX_REPORTS   = 10;
    localparam int         SETTLE_CYCLES = 4;     // longest item latency plus margin
    localparam int         HOLD_CYCLES   = 300;
    localparam int         STALE_KEEP    = 16;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    gha_in_t          in_item;
    logic             out_valid;
    logic             out_stall;
    gha_out_t         out_item;

    // Predicted pool state
    logic [IDX_W-1:0] free_slots [DEPTH];
    logic [GEN_W-1:0] slot_gen   [DEPTH];
    bit               slot_busy  [DEPTH];
    int               free_left;
    int               pool_slots;

    // Answers owed by the block, oldest first
    gha_out_t            answers_due   [$];
    // Handles the pool currently hands out, and recently retired ones
    logic [HANDLE_W-1:0] live_handles  [$];
    logic [HANDLE_W-1:0] stale_handles [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_request   = 0;
    int mismatch_count = 0;

    generational_handle_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [HANDLE_W-1:0] handle_of(input int gen, input int field);
        return {GEN_W'(gen), INDEX_FIELD_BITS'(field)};
    endfunction

    // Pool reinit on a pool_size write: clamp, all free, generations zero
    function automatic void pool_reinit(input logic [CNT_W-1:0] value);
        int slots;
        slots = int'(value);
        if (slots == 0)
            slots = 1;
        if (slots > DEPTH)
            slots = DEPTH;
        pool_slots = slots;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_gen[i]   = '0;
            slot_busy[i]  = 1'b0;
            free_slots[i] = (i < slots) ? IDX_W'(slots - 1 - i) : '0;
        end
        free_left = slots;
        live_handles.delete();
        stale_handles.delete();
    endfunction

    // A handle is live if its index field names a busy slot of matching generation
    function automatic bit handle_names_live(input logic [HANDLE_W-1:0] h, output int idx);
        logic [INDEX_FIELD_BITS-1:0] field;
        logic [GEN_W-1:0]            gen;
        field = h[INDEX_FIELD_BITS-1:0];
        gen   = h[INDEX_FIELD_BITS +: GEN_W];
        idx   = int'(field) - 1;
        if (field == '0 || idx >= pool_slots)
            return 1'b0;
        return slot_busy[idx] && (slot_gen[idx] == gen);
    endfunction

    // Applies one operation to the predicted pool and returns the answer
    function automatic gha_out_t apply_pool_op(input gha_in_t it);
        gha_out_t r;
        int       idx;
        r = '0;
        case (it.opcode)
            OP_ALLOC:
            begin
                if (free_left == 0)
                    r.status = STAT_EXHAUSTED;
                else
                begin
                    free_left--;
                    idx = int'(free_slots[free_left]);
                    slot_busy[idx] = 1'b1;
                    r.handle_out = {slot_gen[idx], INDEX_FIELD_BITS'(idx + 1)};
                end
            end
            OP_FREE:
            begin
                if (handle_names_live(it.handle_in, idx) && free_left < pool_slots)
                begin
                    free_slots[free_left] = IDX_W'(idx);
                    free_left++;
                    slot_gen[idx]  = slot_gen[idx] + 1'b1;
                    slot_busy[idx] = 1'b0;
                end
                else
                    r.status = STAT_BAD;
            end
            OP_CHECK:
                r.is_valid = handle_names_live(it.handle_in, idx);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input gha_out_t want,
                                            input gha_out_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected handle_out=%h status=%0d is_valid=%0b, got %h %0d %0b",
                     $time, what, want.handle_out, want.status, want.is_valid,
                     got.handle_out, got.status, got.is_valid);
    endfunction

    function automatic void check_answer(input gha_out_t want, input gha_out_t got);
        string bad;
        bad = "";
        if (got.handle_out !== want.handle_out)
            bad = {bad, " handle_out"};
        if (got.status !== want.status)
            bad = {bad, " status"};
        if (got.is_valid !== want.is_valid)
            bad = {bad, " is_valid"};
        if (bad != "")
            report_mismatch({"wrong", bad}, want, got);
    endfunction

    // Output transfers are checked against the oldest owed answer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
                report_mismatch("result with nothing outstanding", '0, out_item);
            else
                check_answer(answers_due.pop_front(), out_item);
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Offers one item from a falling edge and returns at the falling edge
    // after its transfer; valid stays high for a following item.
    task automatic send_item(input logic [1:0] op, input logic [HANDLE_W-1:0] h);
        gha_in_t  it;
        gha_out_t r;
        it.opcode    = op;
        it.handle_in = h;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = apply_pool_op(it);
        answers_due.push_back(r);
        // track which handles are out, for well-formed traffic
        if (op == OP_ALLOC && r.status == STAT_OK)
            live_handles.push_back(r.handle_out);
        if (op == OP_FREE && r.status == STAT_OK)
        begin
            for (int i = 0; i < live_handles.size(); i++)
                if (live_handles[i] == h)
                begin
                    live_handles.delete(i);
                    break;
                end
            stale_handles.push_back(h);
            if (stale_handles.size() > STALE_KEEP)
                void'(stale_handles.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic drain_answers();
        in_valid = 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write only with the block idle; it starts a clearing pass
    task automatic write_pool_size(input logic [CNT_W-1:0] value);
        drain_answers();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        pool_reinit(value);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Full pool after reset: handle rules on free and check
    task automatic test_fresh_pool();
        send_item(OP_ALLOC, HANDLE_W'($urandom));
        send_item(OP_ALLOC, '0);
        send_item(OP_CHECK, handle_of(0, 1));
        send_item(OP_CHECK, '0);
        send_item(OP_FREE, '0);
        send_item(OP_FREE, handle_of(8'hFF, 0));        // index field zero
        send_item(OP_FREE, handle_of(0, DEPTH + 1));    // index past the pool
        send_item(OP_FREE, '1);
        send_item(OP_FREE, handle_of(1, 1));            // wrong generation
        send_item(OP_FREE, handle_of(0, 1));
        send_item(OP_FREE, handle_of(0, 1));            // double free
        send_item(OP_CHECK, handle_of(0, 1));           // stale
        send_item(OP_ALLOC, '0);                        // slot 0 again, generation 1
        send_item(OP_FREE, handle_of(0, 3));            // never allocated
        send_item(OP_UNUSED, '1);
    endtask

    // Pool size clamping and exhaustion
    task automatic test_pool_size_limits();
        write_pool_size('0);                            // taken as one slot
        send_item(OP_ALLOC, '1);
        send_item(OP_ALLOC, '0);                        // exhausted
        send_item(OP_FREE, handle_of(0, 2));            // beyond a one-slot pool
        send_item(OP_FREE, handle_of(0, 1));
        send_item(OP_CHECK, handle_of(0, 1));
        write_pool_size('1);                            // clamps to full depth
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, handle_of(0, DEPTH));        // last slot, not busy
        send_item(OP_CHECK, handle_of(0, 1));
        write_pool_size(CNT_W'(3));
        repeat (4) send_item(OP_ALLOC, HANDLE_W'($urandom));
        send_item(OP_FREE, handle_of(0, 2));
        send_item(OP_ALLOC, '0);
    endtask

    // One slot recycled past 256 frees so its generation wraps
    task automatic test_generation_wrap();
        logic [HANDLE_W-1:0] h;
        write_pool_size(CNT_W'(1));
        for (int n = 0; n < 260; n++)
        begin
            send_item(OP_ALLOC, HANDLE_W'($urandom));
            h = live_handles[0];
            if (n % 16 == 0)
                send_item(OP_CHECK, h);
            send_item(OP_FREE, h);
            if (n % 16 == 8)
                send_item(OP_FREE, h);
        end
    endtask

    // Receiver holds off while items keep coming, so the block backs up
    task automatic test_output_holdoff();
        write_pool_size(CNT_W'(DEPTH));
        // start the hold-off only once the clearing pass is over
        while (in_stall)
            @(negedge clk);
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 40; n++)
            send_item((n % 4 == 3) ? OP_CHECK : OP_ALLOC, handle_of(0, n));
    endtask

    // Mostly well-formed alloc/free/check on live handles, some noise,
    // in blocks that each start from a freshly sized pool
    task automatic test_random_traffic(input int n_items);
        int                  done;
        int                  block_len;
        int                  pick;
        int                  slots;
        logic [HANDLE_W-1:0] h;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                slots = 1;
            else if (pick < 35)
                slots = 2;
            else if (pick < 75)
                slots = $urandom_range(3, 24);
            else if (pick < 92)
                slots = $urandom_range(25, 300);
            else
                slots = $urandom_range(0, 2047);
            write_pool_size(CNT_W'(slots));
            block_len = $urandom_range(60, 140);
            for (int n = 0; n < block_len && done < n_items; n++)
            begin
                pick = $urandom_range(99);
                h    = HANDLE_W'($urandom);
                if (pick < 8)
                    send_item(2'($urandom), h);
                else if (pick < 48 || live_handles.size() == 0)
                    send_item(OP_ALLOC, h);
                else if (pick < 76)
                    send_item(OP_FREE,
                              live_handles[$urandom_range(live_handles.size() - 1)]);
                else if (pick < 86)
                    send_item(OP_CHECK,
                              live_handles[$urandom_range(live_handles.size() - 1)]);
                else if (pick < 93 && stale_handles.size() != 0)
                    send_item(OP_FREE,
                              stale_handles[$urandom_range(stale_handles.size() - 1)]);
                else
                    // near miss: a live handle with one bit flipped
                    send_item(OP_CHECK,
                              live_handles[$urandom_range(live_handles.size() - 1)]
                              ^ (HANDLE_W'(1) << $urandom_range(HANDLE_W - 1)));
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_item   = '0;
        pool_reinit(CNT_W'(DEPTH));
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(18, 70);
        test_fresh_pool();
        test_pool_size_limits();
        test_random_traffic(430);

        set_idling(70, 18);
        test_generation_wrap();
        test_random_traffic(430);

        set_idling(0, 0);
        test_output_holdoff();
        test_random_traffic(430);

        drain_answers();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/gha_pkg.sv
sv/gha_ram.sv
sv/gha_ctrl.sv
sv/generational_handle_allocator_unit.sv
bench/tb_generational_handle_allocator_unit.sv
